@@ hw/rtl/ptw_pkg.sv @@
// Shared constants, payload types and a ring-distance helper for the page table walker.
package ptw_pkg;

    localparam int OFFSET_BITS  = 4;
    localparam int TABLE_LEVELS = 3;
    localparam int FRAME_COUNT  = 64;
    localparam int WORD_BITS    = 32;

    localparam int VA_BITS      = 17;
    localparam int DATA_BITS    = 32;
    localparam int PAGE_WORDS   = 1 << OFFSET_BITS;
    localparam int PN_BITS      = OFFSET_BITS * TABLE_LEVELS;
    localparam int PAGE_COUNT   = 1 << PN_BITS;
    localparam int VM_WORDS     = 1 << (PN_BITS + OFFSET_BITS);
    localparam int FRAME_BITS   = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int PM_DEPTH     = FRAME_COUNT * PAGE_WORDS;
    localparam int LVL_BITS     = (TABLE_LEVELS > 1) ? $clog2(TABLE_LEVELS) : 1;

    typedef struct packed {
        logic                        action;
        logic [VA_BITS-1:0]          virtual_address;
        logic signed [DATA_BITS-1:0] write_value;
    } t_in;

    typedef struct packed {
        logic                        ok;
        logic signed [DATA_BITS-1:0] read_value;
    } t_out;

    // Shorter way around a ring of PAGE_COUNT pages.
    function automatic logic [PN_BITS-1:0] ring_dist(input logic [PN_BITS-1:0] a,
                                                    input logic [PN_BITS-1:0] b);
        logic [PN_BITS-1:0] d;
        logic [PN_BITS:0]   alt;
        d   = (a > b) ? (a - b) : (b - a);
        alt = (PN_BITS+1)'(PAGE_COUNT) - {1'b0, d};
        return (alt > {1'b0, d}) ? d : alt[PN_BITS-1:0];
    endfunction

endpackage

@@ hw/rtl/ptw_ram.sv @@
// Simple dual-port synchronous RAM, one write and one registered read port.
module ptw_ram
    import ptw_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

@@ hw/rtl/ptw_seq.sv @@
// Walk sequencer: table walk, frame search passes, swap copies and the access.
module ptw_seq
    import ptw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_in  i_req,
    output logic o_idle,
    output logic o_done,
    output t_out o_rsp,
    input  logic i_ack
);

    localparam int PM_AW = FRAME_BITS + OFFSET_BITS;
    localparam int SW_AW = PN_BITS + OFFSET_BITS;

    localparam logic [4:0] S_CLR    = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_LVL_RD = 5'd2;
    localparam logic [4:0] S_LVL_EV = 5'd3;
    localparam logic [4:0] S_E_ISS  = 5'd4;
    localparam logic [4:0] S_E_EV   = 5'd5;
    localparam logic [4:0] S_T_ISS  = 5'd6;
    localparam logic [4:0] S_T_EV   = 5'd7;
    localparam logic [4:0] S_DECIDE = 5'd8;
    localparam logic [4:0] S_CLEAR  = 5'd9;
    localparam logic [4:0] S_SWO    = 5'd10;
    localparam logic [4:0] S_UNLINK = 5'd11;
    localparam logic [4:0] S_LINK   = 5'd12;
    localparam logic [4:0] S_SP_RD  = 5'd13;
    localparam logic [4:0] S_SP_EV  = 5'd14;
    localparam logic [4:0] S_SWI    = 5'd15;
    localparam logic [4:0] S_ACC    = 5'd16;
    localparam logic [4:0] S_ACC_EV = 5'd17;
    localparam logic [4:0] S_DONE   = 5'd18;

    logic [4:0]             r_state, n_state;
    t_in                    r_req, n_req;
    t_out                   r_rsp, n_rsp;
    logic [LVL_BITS-1:0]    r_lvl, n_lvl;
    logic [FRAME_BITS-1:0]  r_f, n_f;
    logic [FRAME_BITS-1:0]  r_nxt, n_nxt;
    logic [LVL_BITS-1:0]    r_d, n_d;
    logic [FRAME_BITS-1:0]  r_cf, n_cf;
    logic [OFFSET_BITS:0]   r_ci, n_ci;
    logic                   r_nz, n_nz;
    logic [PN_BITS-1:0]     r_pfx, n_pfx;
    logic [FRAME_BITS-1:0]  r_stk [TABLE_LEVELS];
    logic [FRAME_BITS-1:0]  n_stk [TABLE_LEVELS];
    logic [FRAME_BITS-1:0]  r_max, n_max;
    logic                   r_vfound, n_vfound;
    logic [FRAME_BITS-1:0]  r_vframe, n_vframe;
    logic [PN_BITS-1:0]     r_vpage, n_vpage;
    logic [FRAME_BITS-1:0]  r_vparent, n_vparent;
    logic [OFFSET_BITS-1:0] r_vslot, n_vslot;
    logic [PN_BITS-1:0]     r_vdist, n_vdist;
    logic [OFFSET_BITS:0]   r_k, n_k;
    logic [FRAME_BITS-1:0]  r_cfr, n_cfr;
    logic [4:0]             r_ret, n_ret;
    logic [PN_BITS-1:0]     r_clr, n_clr;

    logic                   pm_we;
    logic [PM_AW-1:0]       pm_waddr, pm_raddr;
    logic [WORD_BITS-1:0]   pm_wdata, pm_rdata;
    logic                   sw_we;
    logic [SW_AW-1:0]       sw_waddr, sw_raddr;
    logic [WORD_BITS-1:0]   sw_wdata, sw_rdata;
    logic                   sp_we;
    logic [PN_BITS-1:0]     sp_waddr, sp_raddr;
    logic [0:0]             sp_wdata, sp_rdata;

    logic [PN_BITS-1:0]     w_page;
    logic [OFFSET_BITS-1:0] w_off;
    logic [PN_BITS-1:0]     w_lsh;
    logic [OFFSET_BITS-1:0] w_bits;
    logic [FRAME_BITS-1:0]  w_link;
    logic                   w_last;
    logic                   w_child_tbl;
    logic [PN_BITS+OFFSET_BITS-1:0] w_pfx_ext;
    logic [PN_BITS-1:0]     w_leaf;
    logic [PN_BITS-1:0]     w_dist;
    logic [FRAME_BITS:0]    w_m1;
    logic [OFFSET_BITS:0]   w_km1;

    ptw_ram #(.DEPTH(PM_DEPTH), .WIDTH(WORD_BITS)) u_pm (
        .i_clk(i_clk), .i_we(pm_we), .i_waddr(pm_waddr), .i_wdata(pm_wdata),
        .i_raddr(pm_raddr), .o_rdata(pm_rdata)
    );

    ptw_ram #(.DEPTH(VM_WORDS), .WIDTH(WORD_BITS)) u_swap (
        .i_clk(i_clk), .i_we(sw_we), .i_waddr(sw_waddr), .i_wdata(sw_wdata),
        .i_raddr(sw_raddr), .o_rdata(sw_rdata)
    );

    ptw_ram #(.DEPTH(PAGE_COUNT), .WIDTH(1)) u_present (
        .i_clk(i_clk), .i_we(sp_we), .i_waddr(sp_waddr), .i_wdata(sp_wdata),
        .i_raddr(sp_raddr), .o_rdata(sp_rdata)
    );

    assign w_page      = r_req.virtual_address[PN_BITS+OFFSET_BITS-1:OFFSET_BITS];
    assign w_off       = r_req.virtual_address[OFFSET_BITS-1:0];
    assign w_lsh       = w_page >> (OFFSET_BITS * (TABLE_LEVELS - 1 - int'(r_lvl)));
    assign w_bits      = w_lsh[OFFSET_BITS-1:0];
    assign w_link      = (pm_rdata < WORD_BITS'(FRAME_COUNT)) ?
                         pm_rdata[FRAME_BITS-1:0] : '0;
    assign w_last      = (r_lvl == LVL_BITS'(TABLE_LEVELS - 1));
    assign w_child_tbl = (int'(r_d) + 1 < TABLE_LEVELS);
    assign w_pfx_ext   = {r_pfx, r_ci[OFFSET_BITS-1:0]};
    assign w_leaf      = w_pfx_ext[PN_BITS-1:0];
    assign w_dist      = ring_dist(w_leaf, w_page);
    assign w_m1        = {1'b0, r_max} + 1'b1;
    assign w_km1       = r_k - 1'b1;

    assign o_idle = (r_state == S_IDLE);
    assign o_done = (r_state == S_DONE);
    assign o_rsp  = r_rsp;

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_rsp     = r_rsp;
        n_lvl     = r_lvl;
        n_f       = r_f;
        n_nxt     = r_nxt;
        n_d       = r_d;
        n_cf      = r_cf;
        n_ci      = r_ci;
        n_nz      = r_nz;
        n_pfx     = r_pfx;
        n_stk     = r_stk;
        n_max     = r_max;
        n_vfound  = r_vfound;
        n_vframe  = r_vframe;
        n_vpage   = r_vpage;
        n_vparent = r_vparent;
        n_vslot   = r_vslot;
        n_vdist   = r_vdist;
        n_k       = r_k;
        n_cfr     = r_cfr;
        n_ret     = r_ret;
        n_clr     = r_clr;
        pm_we     = 1'b0;
        pm_waddr  = '0;
        pm_wdata  = '0;
        pm_raddr  = '0;
        sw_we     = 1'b0;
        sw_waddr  = '0;
        sw_wdata  = '0;
        sw_raddr  = '0;
        sp_we     = 1'b0;
        sp_waddr  = '0;
        sp_wdata  = '0;
        sp_raddr  = '0;

        case (r_state)
            S_CLR: begin
                sp_we    = 1'b1;
                sp_waddr = r_clr;
                // zero the physical words alongside the present bits
                if ({1'b0, r_clr} < (PN_BITS+1)'(PM_DEPTH)) begin
                    pm_we    = 1'b1;
                    pm_waddr = r_clr[PM_AW-1:0];
                end
                n_clr    = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_req = i_req;
                    n_lvl = '0;
                    n_f   = '0;
                    if (i_req.virtual_address >= VA_BITS'(VM_WORDS)) begin
                        n_rsp   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_LVL_RD;
                    end
                end
            end
            S_LVL_RD: begin
                pm_raddr = {r_f, w_bits};
                n_state  = S_LVL_EV;
            end
            S_LVL_EV: begin
                if (w_link != '0) begin
                    n_f = w_link;
                    if (w_last) begin
                        n_state = S_SP_RD;
                    end else begin
                        n_lvl   = r_lvl + 1'b1;
                        n_state = S_LVL_RD;
                    end
                end else begin
                    n_d      = '0;
                    n_cf     = '0;
                    n_ci     = '0;
                    n_nz     = 1'b0;
                    n_pfx    = '0;
                    n_max    = '0;
                    n_vfound = 1'b0;
                    // the root is skipped when it is the frame just reached
                    n_state  = (r_f == '0) ? S_T_ISS : S_E_ISS;
                end
            end
            S_E_ISS: begin
                if (r_ci[OFFSET_BITS]) begin
                    if (!r_nz && r_cf != '0) begin
                        // empty table frame: unlink it and take it
                        pm_we    = 1'b1;
                        pm_waddr = {r_stk[r_d - 1'b1], r_pfx[OFFSET_BITS-1:0]};
                        n_nxt    = r_cf;
                        n_state  = S_LINK;
                    end else if (r_d == '0) begin
                        n_d      = '0;
                        n_cf     = '0;
                        n_ci     = '0;
                        n_nz     = 1'b0;
                        n_pfx    = '0;
                        n_max    = '0;
                        n_vfound = 1'b0;
                        n_state  = S_T_ISS;
                    end else begin
                        n_cf  = r_stk[r_d - 1'b1];
                        n_ci  = {1'b0, r_pfx[OFFSET_BITS-1:0]} + 1'b1;
                        n_pfx = r_pfx >> OFFSET_BITS;
                        n_nz  = 1'b1;
                        n_d   = r_d - 1'b1;
                    end
                end else begin
                    pm_raddr = {r_cf, r_ci[OFFSET_BITS-1:0]};
                    n_state  = S_E_EV;
                end
            end
            S_E_EV: begin
                n_state = S_E_ISS;
                if (pm_rdata != '0) begin
                    n_nz = 1'b1;
                end
                if (w_link != '0 && w_child_tbl && w_link != r_f) begin
                    n_stk[r_d] = r_cf;
                    n_cf       = w_link;
                    n_ci       = '0;
                    n_nz       = 1'b0;
                    n_pfx      = w_leaf;
                    n_d        = r_d + 1'b1;
                end else begin
                    n_ci = r_ci + 1'b1;
                end
            end
            S_T_ISS: begin
                if (r_ci[OFFSET_BITS]) begin
                    if (r_d == '0) begin
                        n_state = S_DECIDE;
                    end else begin
                        n_cf  = r_stk[r_d - 1'b1];
                        n_ci  = {1'b0, r_pfx[OFFSET_BITS-1:0]} + 1'b1;
                        n_pfx = r_pfx >> OFFSET_BITS;
                        n_d   = r_d - 1'b1;
                    end
                end else begin
                    pm_raddr = {r_cf, r_ci[OFFSET_BITS-1:0]};
                    n_state  = S_T_EV;
                end
            end
            S_T_EV: begin
                n_state = S_T_ISS;
                n_ci    = r_ci + 1'b1;
                if (w_link != '0) begin
                    if (w_link > r_max) begin
                        n_max = w_link;
                    end
                    if (w_child_tbl) begin
                        n_stk[r_d] = r_cf;
                        n_cf       = w_link;
                        n_ci       = '0;
                        n_pfx      = w_leaf;
                        n_d        = r_d + 1'b1;
                    end else if (!r_vfound || w_dist > r_vdist) begin
                        // strictly farther page wins, first one keeps ties
                        n_vfound  = 1'b1;
                        n_vframe  = w_link;
                        n_vpage   = w_leaf;
                        n_vparent = r_cf;
                        n_vslot   = r_ci[OFFSET_BITS-1:0];
                        n_vdist   = w_dist;
                    end
                end
            end
            S_DECIDE: begin
                n_k = '0;
                if (w_m1 < (FRAME_BITS+1)'(FRAME_COUNT)) begin
                    n_nxt   = w_m1[FRAME_BITS-1:0];
                    n_cfr   = w_m1[FRAME_BITS-1:0];
                    n_ret   = S_LINK;
                    n_state = S_CLEAR;
                end else if (r_vfound) begin
                    n_state = S_SWO;
                end else begin
                    n_rsp   = '0;
                    n_state = S_DONE;
                end
            end
            S_CLEAR: begin
                pm_we    = 1'b1;
                pm_waddr = {r_cfr, r_k[OFFSET_BITS-1:0]};
                n_k      = r_k + 1'b1;
                if (r_k == (OFFSET_BITS+1)'(PAGE_WORDS - 1)) begin
                    n_state = r_ret;
                end
            end
            S_SWO: begin
                pm_raddr = {r_vframe, r_k[OFFSET_BITS-1:0]};
                if (r_k != '0) begin
                    sw_we    = 1'b1;
                    sw_waddr = {r_vpage, w_km1[OFFSET_BITS-1:0]};
                    sw_wdata = pm_rdata;
                end
                n_k = r_k + 1'b1;
                if (r_k[OFFSET_BITS]) begin
                    sp_we    = 1'b1;
                    sp_waddr = r_vpage;
                    sp_wdata = 1'b1;
                    n_k      = '0;
                    if (w_last) begin
                        n_state = S_UNLINK;
                    end else begin
                        n_cfr   = r_vframe;
                        n_ret   = S_UNLINK;
                        n_state = S_CLEAR;
                    end
                end
            end
            S_UNLINK: begin
                pm_we    = 1'b1;
                pm_waddr = {r_vparent, r_vslot};
                n_nxt    = r_vframe;
                n_state  = S_LINK;
            end
            S_LINK: begin
                pm_we    = 1'b1;
                pm_waddr = {r_f, w_bits};
                pm_wdata = WORD_BITS'(r_nxt);
                n_f      = r_nxt;
                if (w_last) begin
                    n_state = S_SP_RD;
                end else begin
                    n_lvl   = r_lvl + 1'b1;
                    n_state = S_LVL_RD;
                end
            end
            S_SP_RD: begin
                sp_raddr = w_page;
                n_state  = S_SP_EV;
            end
            S_SP_EV: begin
                n_k     = '0;
                n_state = sp_rdata[0] ? S_SWI : S_ACC;
            end
            S_SWI: begin
                sw_raddr = {w_page, r_k[OFFSET_BITS-1:0]};
                if (r_k != '0) begin
                    pm_we    = 1'b1;
                    pm_waddr = {r_f, w_km1[OFFSET_BITS-1:0]};
                    pm_wdata = sw_rdata;
                end
                n_k = r_k + 1'b1;
                if (r_k[OFFSET_BITS]) begin
                    sp_we    = 1'b1;
                    sp_waddr = w_page;
                    n_state  = S_ACC;
                end
            end
            S_ACC: begin
                if (r_req.action) begin
                    pm_we            = 1'b1;
                    pm_waddr         = {r_f, w_off};
                    pm_wdata         = WORD_BITS'(unsigned'(r_req.write_value));
                    n_rsp.ok         = 1'b1;
                    n_rsp.read_value = '0;
                    n_state          = S_DONE;
                end else begin
                    pm_raddr = {r_f, w_off};
                    n_state  = S_ACC_EV;
                end
            end
            S_ACC_EV: begin
                n_rsp.ok         = 1'b1;
                n_rsp.read_value = DATA_BITS'(pm_rdata);
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (i_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_rsp     <= n_rsp;
        r_lvl     <= n_lvl;
        r_f       <= n_f;
        r_nxt     <= n_nxt;
        r_d       <= n_d;
        r_cf      <= n_cf;
        r_ci      <= n_ci;
        r_nz      <= n_nz;
        r_pfx     <= n_pfx;
        r_stk     <= n_stk;
        r_max     <= n_max;
        r_vfound  <= n_vfound;
        r_vframe  <= n_vframe;
        r_vpage   <= n_vpage;
        r_vparent <= n_vparent;
        r_vslot   <= n_vslot;
        r_vdist   <= n_vdist;
        r_k       <= n_k;
        r_cfr     <= n_cfr;
        r_ret     <= n_ret;
    end

endmodule

@@ hw/rtl/page_table_walk_with_eviction.sv @@
// Top level: virtual word access through a page table walk with eviction.
//
// Input channel (i_in_valid / o_in_ready, payload i_in_data) carries one
// transaction: a read or write of one word at a virtual address. Output
// channel (o_out_valid / i_out_ready, payload o_out_data) returns one
// transaction per input: ok and the word read (zero on a write or failure).
// An out-of-range address answers without a walk; a walk that hits at every
// level reads one entry per level, then checks the swap-present bit and
// does the access (a read waits for the word). A missing entry runs up to
// two depth-first passes over the table frames, then a frame clear, a swap
// copy, or a swap copy followed by a clear. A page held in swap adds a
// copy back. All of it runs on the single read port of the physical
// memory, one transaction at a time.
// After reset the swap-present bits are cleared one per cycle, all PAGE_COUNT
// of them (4096 at default sizes), with o_in_ready low; the physical words
// are zeroed during the same pass.
// A finished result sits in the output register; the next transaction is
// taken while it waits. If the receiver stalls, the following result holds
// inside the sequencer until the output register frees.
module page_table_walk_with_eviction
    import ptw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic w_idle;
    logic w_done;
    logic w_ack;
    logic w_accept;
    t_out w_rsp;
    logic r_out_valid;
    t_out r_out;

    assign o_in_ready = w_idle;
    assign w_accept   = i_in_valid && w_idle;

    // hand the result over once the output register is free or draining
    assign w_ack = w_done && (!r_out_valid || i_out_ready);

    ptw_seq u_seq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_accept),
        .i_req  (i_in_data),
        .o_idle (w_idle),
        .o_done (w_done),
        .o_rsp  (w_rsp),
        .i_ack  (w_ack)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ack) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ack) begin
            r_out <= w_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a new result only appears after the sequencer finished a transaction
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_done))
        else $error("result shown without a finished transaction");

    // a failed transaction never carries data
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.ok) |-> (o_out_data.read_value == '0))
        else $error("failed transaction with nonzero read value");

    // the clearing pass follows reset, so nothing is taken right after it
    a_clear_after_reset: assert property (@(posedge i_clk)
        (i_rst_n && $past(i_rst_n) == 1'b0) |-> !o_in_ready)
        else $error("input taken during the swap-present clearing pass");

    // while a result waits in the sequencer no second transaction is accepted
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> !o_in_ready)
        else $error("input ready while a result is pending in the sequencer");

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the page table walker with cyclic-distance eviction.
module tb;
    import ptw_pkg::*;

    // Clock, reset and ports of the block under test
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    page_table_walk_with_eviction uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    localparam int RANDOM_ITEMS = 515;

    // Shadow copy of the memory system: physical frames, swap images and
    // the per-page flag that says a swap image is valid.
    bit [31:0] shadow_phys [0:PM_DEPTH-1];
    bit [31:0] shadow_swap [0:VM_WORDS-1];
    bit        shadow_in_swap [0:PAGE_COUNT-1];

    // Best eviction candidate found by the depth-first scan
    bit          vic_found;
    int unsigned vic_frame, vic_page, vic_parent, vic_slot, vic_dist;

    t_out expected_results [$];
    int   error_count = 0;

    // Child frame named by a table entry; out-of-range entries read as empty.
    function automatic int unsigned child_of(int unsigned f, int unsigned i);
        bit [31:0] v;
        v = shadow_phys[f * PAGE_WORDS + i];
        return (v < FRAME_COUNT) ? v : 0;
    endfunction

    function automatic void zero_frame(int unsigned f);
        for (int i = 0; i < PAGE_WORDS; i++) shadow_phys[f * PAGE_WORDS + i] = '0;
    endfunction

    function automatic bit frame_empty(int unsigned f);
        for (int i = 0; i < PAGE_WORDS; i++)
            if (shadow_phys[f * PAGE_WORDS + i] != 0) return 1'b0;
        return 1'b1;
    endfunction

    // Depth-first search for an empty table frame; unlink it when found.
    function automatic int unsigned reclaim_table(int lvl, int unsigned f,
            int unsigned parent, int unsigned slot, int unsigned skip);
        int unsigned c, r;
        if (lvl == TABLE_LEVELS || f == skip) return 0;
        if (frame_empty(f)) begin
            shadow_phys[parent * PAGE_WORDS + slot] = '0;
            return f;
        end
        for (int i = 0; i < PAGE_WORDS; i++) begin
            c = child_of(f, i);
            if (c != 0) begin
                r = reclaim_table(lvl + 1, c, f, i, skip);
                if (r != 0) return r;
            end
        end
        return 0;
    endfunction

    function automatic int unsigned highest_frame(int lvl, int unsigned f);
        int unsigned c, r, m;
        m = f;
        if (lvl == TABLE_LEVELS) return f;
        for (int i = 0; i < PAGE_WORDS; i++) begin
            c = child_of(f, i);
            if (c != 0) begin
                r = highest_frame(lvl + 1, c);
                if (r > m) m = r;
            end
        end
        return m;
    endfunction

    function automatic int unsigned page_gap(int unsigned a, int unsigned b);
        int unsigned d;
        d = (a > b) ? a - b : b - a;
        return ((PAGE_COUNT - d) > d) ? d : PAGE_COUNT - d;
    endfunction

    // Keep the first resident page with the strictly greatest ring distance.
    function automatic void scan_victims(int lvl, int unsigned f, int unsigned prefix,
            int unsigned parent, int unsigned slot, int unsigned want);
        int unsigned c, d;
        if (lvl == TABLE_LEVELS) begin
            d = page_gap(prefix, want);
            if (!vic_found || d > vic_dist) begin
                vic_found  = 1'b1;
                vic_frame  = f;
                vic_page   = prefix;
                vic_parent = parent;
                vic_slot   = slot;
                vic_dist   = d;
            end
            return;
        end
        for (int i = 0; i < PAGE_WORDS; i++) begin
            c = child_of(f, i);
            if (c != 0)
                scan_victims(lvl + 1, c, (prefix << OFFSET_BITS) | i, f, i, want);
        end
    endfunction

    // Apply one access to the shadow state and return the response.
    function automatic t_out predict_access(t_in req);
        t_out        rsp;
        int unsigned va, off, page, f, nxt, bits, m;
        rsp = '0;
        va = 32'(req.virtual_address);
        if (va >= VM_WORDS) return rsp;
        off  = va % PAGE_WORDS;
        page = va >> OFFSET_BITS;
        f    = 0;
        for (int lvl = 0; lvl < TABLE_LEVELS; lvl++) begin
            bits = (page >> (OFFSET_BITS * (TABLE_LEVELS - 1 - lvl))) % PAGE_WORDS;
            nxt  = child_of(f, bits);
            if (nxt == 0) begin
                nxt = reclaim_table(0, 0, 0, 0, f);
                if (nxt == 0) begin
                    m = highest_frame(0, 0);
                    if (m + 1 < FRAME_COUNT) begin
                        nxt = m + 1;
                        zero_frame(nxt);
                    end else begin
                        vic_found = 1'b0;
                        vic_dist  = 0;
                        scan_victims(0, 0, 0, 0, 0, page);
                        if (!vic_found) return rsp;
                        for (int i = 0; i < PAGE_WORDS; i++)
                            shadow_swap[vic_page * PAGE_WORDS + i] =
                                shadow_phys[vic_frame * PAGE_WORDS + i];
                        shadow_in_swap[vic_page] = 1'b1;
                        if (lvl != TABLE_LEVELS - 1) zero_frame(vic_frame);
                        shadow_phys[vic_parent * PAGE_WORDS + vic_slot] = '0;
                        nxt = vic_frame;
                    end
                end
                shadow_phys[f * PAGE_WORDS + bits] = nxt;
            end
            f = nxt;
        end
        if (shadow_in_swap[page]) begin
            for (int i = 0; i < PAGE_WORDS; i++)
                shadow_phys[f * PAGE_WORDS + i] = shadow_swap[page * PAGE_WORDS + i];
            shadow_in_swap[page] = 1'b0;
        end
        rsp.ok = 1'b1;
        if (req.action) shadow_phys[f * PAGE_WORDS + off] = req.write_value;
        else            rsp.read_value = shadow_phys[f * PAGE_WORDS + off];
        return rsp;
    endfunction

    // Directed rows: known marks a response that is typed in directly.
    typedef struct packed {
        bit   known;
        t_in  req;
        t_out rsp;
    } dir_row_t;

    localparam int DIR_ROWS = 22;
    dir_row_t dir_rows [0:DIR_ROWS-1] = '{
        '{1'b1, '{1'b0, 17'd0,      32'sd0},           '{1'b1, 32'sd0}},
        '{1'b1, '{1'b0, 17'd65535,  32'sd0},           '{1'b1, 32'sd0}},
        '{1'b1, '{1'b0, 17'd65536,  32'sd0},           '{1'b0, 32'sd0}},
        '{1'b1, '{1'b0, 17'd131071, 32'sd0},           '{1'b0, 32'sd0}},
        '{1'b1, '{1'b1, 17'd131071, 32'hFFFFFFFF},     '{1'b0, 32'sd0}},
        '{1'b1, '{1'b1, 17'd0,      32'h7FFFFFFF},     '{1'b1, 32'sd0}},
        '{1'b1, '{1'b0, 17'd0,      32'h12345678},     '{1'b1, 32'h7FFFFFFF}},
        '{1'b1, '{1'b1, 17'd65535,  32'h80000000},     '{1'b1, 32'sd0}},
        '{1'b1, '{1'b0, 17'd65535,  32'sd0},           '{1'b1, 32'h80000000}},
        '{1'b0, '{1'b1, 17'd15,     32'hFFFFFFFF},     '0},
        '{1'b0, '{1'b0, 17'd15,     32'sd0},           '0},
        '{1'b0, '{1'b1, 17'd16,     32'h5A5A5A5A},     '0},
        '{1'b0, '{1'b0, 17'd16,     32'sd0},           '0},
        '{1'b0, '{1'b1, 17'h0FFF0,  32'hA5A5A5A5},     '0},
        '{1'b0, '{1'b1, 17'h08000,  32'h00000001},     '0},
        '{1'b0, '{1'b1, 17'h07FF0,  32'hFFFF0000},     '0},
        '{1'b0, '{1'b0, 17'h08000,  32'sd0},           '0},
        '{1'b0, '{1'b1, 17'h01230,  32'h0000FFFF},     '0},
        '{1'b0, '{1'b1, 17'h0ABC7,  32'hDEADBEEF},     '0},
        '{1'b0, '{1'b0, 17'h0ABC7,  32'sd0},           '0},
        '{1'b0, '{1'b0, 17'h1FFFF,  32'sd0},           '0},
        '{1'b0, '{1'b0, 17'h0FFF0,  32'sd0},           '0}
    };

    int burst_left = 0;

    // Present one transaction, hold it until accepted, then record what the
    // shadow model predicts (or the typed value). Drop valid for a random gap
    // at the end of a burst.
    task automatic send_access(t_in req, bit known, t_out typed);
        t_out predicted;
        int   gap;
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = predict_access(req);
        expected_results.push_back(known ? typed : predicted);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // Hold off the sender until every outstanding response is back.
    task automatic drain_responses();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Stimulus
    initial begin
        int unsigned recent_pages [0:15];
        t_in         req;
        int unsigned pick;
        for (int i = 0; i < 16; i++) recent_pages[i] = $urandom_range(0, PAGE_COUNT - 1);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
            send_access(dir_rows[r].req, dir_rows[r].known, dir_rows[r].rsp);
        drain_responses();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) drain_responses();
            req.action      = 1'($urandom_range(0, 1));
            req.write_value = $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                // out of range: bit 16 set
                req.virtual_address =
                    VA_BITS'($urandom_range(VM_WORDS, (1 << VA_BITS) - 1));
            end else if (pick < 45) begin
                // fresh page anywhere: drives allocation, eviction and swap
                req.virtual_address = VA_BITS'($urandom_range(0, VM_WORDS - 1));
                recent_pages[$urandom_range(0, 15)] =
                    32'(req.virtual_address >> OFFSET_BITS);
            end else begin
                // revisit a recent page, often one that was swapped out
                req.virtual_address =
                    VA_BITS'((recent_pages[$urandom_range(0, 15)] << OFFSET_BITS)
                             | $urandom_range(0, PAGE_WORDS - 1));
            end
            send_access(req, 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Response check and receiver stall pattern
    int stall_mode = 0;
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected response ok=%0d read_value=%h",
                           o_out_data.ok, o_out_data.read_value);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_data.ok !== want.ok) begin
                        $error("ok: expected %0d actual %0d", want.ok, o_out_data.ok);
                        error_count++;
                    end
                    if (o_out_data.read_value !== want.read_value) begin
                        $error("read_value: expected %h actual %h",
                               want.read_value, o_out_data.read_value);
                        error_count++;
                    end
                end
            end
            // advance the stall pattern: always ready, random, or mostly stalled
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                stall_left = $urandom_range(50, 3000);
            end else begin
                stall_left--;
            end
            case (stall_mode)
                0: begin
                    i_out_ready <= 1'b1;
                end
                1: begin
                    i_out_ready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    i_out_ready <= ($urandom_range(0, 7) == 0);
                end
            endcase
        end
    end

    // Run limit
    initial begin
        #400000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
